// ===== hdl/free_extent_coalescer_assert.svh =====
// Assertion macros of the free extent coalescer checker.
// Depends on nothing; included by the checker file.
`ifndef FREE_EXTENT_COALESCER_ASSERT_SVH
`define FREE_EXTENT_COALESCER_ASSERT_SVH

// Clocked property that is ignored while reset is asserted.
`define FEC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define FEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fec_pkg.sv =====
// Shared types, sizes and codes of the free extent coalescer.
// Depends on nothing; used by the top level, fec_align, the checker and the bench.
package fec_pkg;

	// Sizing of the block.
	localparam int CHUNK_ALIGN = 8;
	localparam int MAX_EXTENTS = 64;
	localparam int ADDR_WIDTH  = 32;

	localparam int ALIGN_LOG = $clog2(CHUNK_ALIGN);
	localparam int IDX_W     = $clog2(MAX_EXTENTS);
	localparam int CNT_W     = $clog2(MAX_EXTENTS + 1);

	// Fixed field widths.
	localparam int START_W = 32;
	localparam int SIZE_W  = 32;
	localparam int LEN_W   = 33;
	localparam int END_W   = 34;
	localparam int FREE_W  = 33;
	localparam int COUNT_W = 7;

	// First byte address past the managed address space.
	localparam logic [63:0] ADDR_LIMIT = 64'd1 << ADDR_WIDTH;

	typedef enum logic [2:0] {
		ST_FREED  = 3'd0,
		ST_ZERO   = 3'd1,
		ST_DOUBLE = 3'd2,
		ST_FULL   = 3'd3,
		ST_RANGE  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_INSERT,
		S_FINISH
	} state_t;

	// One free request.
	typedef struct packed {
		logic [START_W-1:0] block_address;
		logic [SIZE_W-1:0]  byte_size;
	} req_t;

	// One result.
	typedef struct packed {
		status_t            status;
		logic [FREE_W-1:0]  free_total;
		logic [COUNT_W-1:0] extent_count;
	} res_t;

	// One entry of the extent table.
	typedef struct packed {
		logic [START_W-1:0] base;
		logic [LEN_W-1:0]   len;
	} ext_t;

endpackage

// ===== hdl/free_extent_coalescer.sv =====
// Top level of the free extent coalescer: sequencer around the extent table.
// Depends on fec_pkg, fec_align and fec_ram.
//
// A free request is taken when start is high and busy is low. A zero size or
// a range past the address space is answered in the next cycle and busy stays
// low. Any other request scans table entries in address order (at most the
// extent count), moves entries to open or close a slot, and writes the new
// extent in a separate insert step when it goes into a slot opened by moves,
// all before its result.
// The table sits in one RAM with one read and one write per cycle, so both the
// scan and the moves advance one entry per cycle. The result is shown for
// exactly one cycle with done high and cannot be held off by the receiver;
// busy falls in that same cycle, so the next request may be taken at once.
// The checks_q register is written through cfg_we and cfg_wdata.
module free_extent_coalescer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  fec_pkg::req_t  request,
	output logic           done,
	output fec_pkg::res_t  result,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);

	localparam int IW = fec_pkg::IDX_W;
	localparam int CW = fec_pkg::CNT_W;
	localparam int EW = fec_pkg::END_W;
	localparam int LW = fec_pkg::LEN_W;

	fec_pkg::state_t state_q, state_d;

	logic                        checks_q;
	logic [CW-1:0]               n_q;
	logic [fec_pkg::FREE_W-1:0]  free_q;
	logic [fec_pkg::START_W-1:0] start_q;
	logic [LW-1:0]               len_q;
	logic [EW-1:0]               end_q;
	logic [CW-1:0]               idx_q;
	logic [CW-1:0]               pos_q;
	fec_pkg::ext_t               pred_q, succ_q;
	logic                        has_pred_q, has_succ_q;
	fec_pkg::status_t            status_q;
	logic                        done_q;
	fec_pkg::res_t               result_q;

	// Aligned view of the incoming request.
	logic [fec_pkg::START_W-1:0] al_base;
	logic [LW-1:0]               al_len;
	logic [EW-1:0]               al_end;
	logic                        al_zero, al_ovf;

	fec_align u_align (
		.request   (request),
		.base      (al_base),
		.len       (al_len),
		.range_end (al_end),
		.zero_size (al_zero),
		.overflow  (al_ovf)
	);

	// Extent table.
	logic                            ram_we;
	logic [IW-1:0]                   ram_waddr, ram_raddr;
	fec_pkg::ext_t                   ram_wdata, rd_ext;
	logic [$bits(fec_pkg::ext_t)-1:0] ram_rdata;

	fec_ram #(
		.DEPTH (fec_pkg::MAX_EXTENTS),
		.WIDTH ($bits(fec_pkg::ext_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_ext = fec_pkg::ext_t'(ram_rdata);

	// Conditions used by the sequencer.
	logic          accept;
	logic          hit, last;
	logic [EW-1:0] pred_end;
	logic          overlap, m_pred, m_succ, full;
	logic [LW-1:0] len_both, len_pred, len_succ;
	logic [CW-1:0] pos_p1;
	logic          more_dn;
	logic [fec_pkg::FREE_W:0] free_sum;
	logic [fec_pkg::FREE_W-1:0] free_sat;

	always_comb begin
		accept   = start && !busy;
		hit      = (rd_ext.base >= start_q);
		last     = ((idx_q + CW'(1)) == n_q);
		pred_end = EW'(pred_q.base) + EW'(pred_q.len);
		overlap  = checks_q &&
			((has_succ_q && (end_q > EW'(succ_q.base))) ||
			 (has_pred_q && (pred_end > EW'(start_q))));
		m_pred   = has_pred_q && (pred_end == EW'(start_q));
		m_succ   = has_succ_q && (end_q == EW'(succ_q.base));
		full     = (n_q >= CW'(fec_pkg::MAX_EXTENTS));
		len_both = LW'(end_q + EW'(succ_q.len) - EW'(pred_q.base));
		len_pred = LW'(end_q - EW'(pred_q.base));
		len_succ = LW'(end_q + EW'(succ_q.len) - EW'(start_q));
		pos_p1   = pos_q + CW'(1);
		more_dn  = (pos_p1 < n_q);
		free_sum = (fec_pkg::FREE_W + 1)'(free_q) + (fec_pkg::FREE_W + 1)'(len_q);
		free_sat = free_sum[fec_pkg::FREE_W] ? '1 : free_sum[fec_pkg::FREE_W-1:0];
	end

	assign busy = (state_q != fec_pkg::S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fec_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and table accesses. Where a read in the same cycle as a write is
	// used, the two target different entries, so no forwarding is needed.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			fec_pkg::S_IDLE: begin
				if (accept && !al_zero && !al_ovf) begin
					state_d = (n_q == '0) ? fec_pkg::S_DECIDE : fec_pkg::S_SEARCH;
				end
			end
			fec_pkg::S_SEARCH: begin
				if (hit || last) begin
					state_d = fec_pkg::S_DECIDE;
				end else begin
					ram_raddr = IW'(idx_q + CW'(1));
				end
			end
			fec_pkg::S_DECIDE: begin
				state_d = fec_pkg::S_FINISH;
				if (overlap) begin
					state_d = fec_pkg::S_FINISH;
				end else if (m_pred && m_succ) begin
					ram_we    = 1'b1;
					ram_waddr = IW'(pos_q - CW'(1));
					ram_wdata = '{base: pred_q.base, len: len_both};
					if (more_dn) begin
						ram_raddr = IW'(pos_p1);
						state_d   = fec_pkg::S_SHIFT_DN;
					end
				end else if (m_pred) begin
					ram_we    = 1'b1;
					ram_waddr = IW'(pos_q - CW'(1));
					ram_wdata = '{base: pred_q.base, len: len_pred};
				end else if (m_succ) begin
					ram_we    = 1'b1;
					ram_waddr = IW'(pos_q);
					ram_wdata = '{base: start_q, len: len_succ};
				end else if (!full) begin
					if (pos_q == n_q) begin
						ram_we    = 1'b1;
						ram_waddr = IW'(pos_q);
						ram_wdata = '{base: start_q, len: len_q};
					end else begin
						ram_raddr = IW'(n_q - CW'(1));
						state_d   = fec_pkg::S_SHIFT_UP;
					end
				end
			end
			fec_pkg::S_SHIFT_DN: begin
				// Close the gap: entry idx moves to idx - 1.
				ram_we    = 1'b1;
				ram_waddr = IW'(idx_q - CW'(1));
				ram_wdata = rd_ext;
				if (idx_q < n_q) begin
					ram_raddr = IW'(idx_q + CW'(1));
				end else begin
					state_d = fec_pkg::S_FINISH;
				end
			end
			fec_pkg::S_SHIFT_UP: begin
				// Open a slot: entry idx moves to idx + 1, highest first.
				ram_we    = 1'b1;
				ram_waddr = IW'(idx_q + CW'(1));
				ram_wdata = rd_ext;
				if (idx_q == pos_q) begin
					state_d = fec_pkg::S_INSERT;
				end else begin
					ram_raddr = IW'(idx_q - CW'(1));
				end
			end
			fec_pkg::S_INSERT: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(pos_q);
				ram_wdata = '{base: start_q, len: len_q};
				state_d   = fec_pkg::S_FINISH;
			end
			fec_pkg::S_FINISH: begin
				state_d = fec_pkg::S_IDLE;
			end
			default: begin
				state_d = fec_pkg::S_IDLE;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checks_q <= 1'b1;
		end else if (cfg_we) begin
			checks_q <= cfg_wdata;
		end
	end

	// Count, free total and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			free_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				fec_pkg::S_IDLE: begin
					if (accept && (al_zero || al_ovf)) begin
						done_q <= 1'b1;
					end
				end
				fec_pkg::S_DECIDE: begin
					if (!overlap) begin
						if (m_pred && m_succ) begin
							n_q    <= n_q - CW'(1);
							free_q <= free_sat;
						end else if (m_pred || m_succ) begin
							free_q <= free_sat;
						end else if (!full) begin
							n_q    <= n_q + CW'(1);
							free_q <= free_sat;
						end
					end
				end
				fec_pkg::S_FINISH: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Request, scan and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			fec_pkg::S_IDLE: begin
				if (accept) begin
					start_q    <= al_base;
					len_q      <= al_len;
					end_q      <= al_end;
					idx_q      <= '0;
					pos_q      <= '0;
					has_pred_q <= 1'b0;
					has_succ_q <= 1'b0;
					result_q.free_total   <= free_q;
					result_q.extent_count <= fec_pkg::COUNT_W'(n_q);
					result_q.status       <= al_zero ? fec_pkg::ST_ZERO : fec_pkg::ST_RANGE;
				end
			end
			fec_pkg::S_SEARCH: begin
				if (hit) begin
					succ_q     <= rd_ext;
					has_succ_q <= 1'b1;
					pos_q      <= idx_q;
				end else begin
					pred_q     <= rd_ext;
					has_pred_q <= 1'b1;
					if (last) begin
						pos_q <= n_q;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
			end
			fec_pkg::S_DECIDE: begin
				if (overlap) begin
					status_q <= fec_pkg::ST_DOUBLE;
				end else if (!m_pred && !m_succ && full) begin
					status_q <= fec_pkg::ST_FULL;
				end else begin
					status_q <= fec_pkg::ST_FREED;
				end
				if (m_pred && m_succ) begin
					idx_q <= pos_p1;
				end else begin
					idx_q <= n_q - CW'(1);
				end
			end
			fec_pkg::S_SHIFT_DN: begin
				idx_q <= idx_q + CW'(1);
			end
			fec_pkg::S_SHIFT_UP: begin
				idx_q <= idx_q - CW'(1);
			end
			fec_pkg::S_FINISH: begin
				result_q.status       <= status_q;
				result_q.free_total   <= free_q;
				result_q.extent_count <= fec_pkg::COUNT_W'(n_q);
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/fec_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; holds the extent table of the coalescer.
module fec_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 65,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/fec_align.sv =====
// Widens a free request outward to the chunk alignment and checks its range.
// Depends on fec_pkg for the request type, widths and the alignment.
module fec_align (
	input  fec_pkg::req_t                    request,
	output logic [fec_pkg::START_W-1:0]      base,
	output logic [fec_pkg::LEN_W-1:0]        len,
	output logic [fec_pkg::END_W-1:0]        range_end,
	output logic                             zero_size,
	output logic                             overflow
);

	localparam logic [fec_pkg::LEN_W-1:0] ALIGN_MASK =
		fec_pkg::LEN_W'(fec_pkg::CHUNK_ALIGN - 1);

	logic [fec_pkg::ALIGN_LOG-1:0] offset;
	logic [fec_pkg::LEN_W-1:0]     padded;

	// Round the start down and the end up to whole chunks.
	always_comb begin
		offset    = request.block_address[fec_pkg::ALIGN_LOG-1:0];
		base      = request.block_address & ~fec_pkg::START_W'(fec_pkg::CHUNK_ALIGN - 1);
		padded    = fec_pkg::LEN_W'(request.byte_size) + fec_pkg::LEN_W'(offset) + ALIGN_MASK;
		len       = padded & ~ALIGN_MASK;
		range_end = fec_pkg::END_W'(base) + fec_pkg::END_W'(len);
		zero_size = (request.byte_size == '0);
		overflow  = (64'(range_end) > fec_pkg::ADDR_LIMIT);
	end

endmodule

// ===== hdl/fec_checker.sv =====
// Port-level checks of the free extent coalescer, bound to its top level.
// Depends on fec_pkg and free_extent_coalescer_assert.svh.
`include "free_extent_coalescer_assert.svh"

module fec_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input fec_pkg::req_t request,
	input logic          done,
	input fec_pkg::res_t result
);

	// A result only follows an accepted item or a cycle of work.
	`FEC_ASSERT(a_done_follows_work, clk, arst_n, done |-> ($past(busy) || $past(start)), "result without a preceding item")

	// An accepted item either starts work or is answered in the next cycle.
	`FEC_ASSERT(a_accept_moves, clk, arst_n, (start && !busy) |=> (busy || done), "accepted item was dropped")

	// A zero size item is answered at once as ignored.
	`FEC_ASSERT(a_zero_size, clk, arst_n, (start && !busy && (request.byte_size == '0)) |=> (done && (result.status == fec_pkg::ST_ZERO)), "zero size item not answered as ignored")

	// Reset holds the block quiet.
	`FEC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!done && !busy), "activity during reset")

endmodule

bind free_extent_coalescer fec_checker u_fec_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for free_extent_coalescer: drives free requests, predicts
// status, free byte total and extent count from its own extent table, and checks each result.
// Depends on fec_pkg and the free_extent_coalescer RTL.
module testbench;
	import fec_pkg::*;

	localparam logic [63:0] FREE_LIMIT = (64'd1 << FREE_W) - 64'd1;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  start = 1'b0;
	logic  busy;
	req_t  request = '0;
	logic  done;
	res_t  result;
	logic  cfg_we;
	logic  cfg_wdata;

	// Items waiting to be sent and results waiting to arrive.
	req_t  pending_frees[$];
	res_t  expected_free_reports[$];
	int    sender_idle_pct = 0;
	int    mismatch_count = 0;

	// Predicted extent table, sorted by base address.
	logic [START_W-1:0] ext_base[MAX_EXTENTS];
	logic [LEN_W-1:0]   ext_len[MAX_EXTENTS];
	int                 ext_count = 0;
	logic [63:0]        free_sum = '0;
	bit                 checks_on = 1'b1;

	// Random stimulus works inside a window of 32 regions of 256 bytes each.
	logic [31:0] window_base;
	bit [31:0]   region_used;

	free_extent_coalescer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one free to the predicted table and return the result it should produce.
	function automatic res_t coalesce_free(req_t req);
		logic [63:0] off, lo, len, hi, pred_end;
		int pos;
		bit has_pred, has_succ, join_pred, join_succ;
		status_t st;
		res_t res;
		st = ST_FREED;
		if (req.byte_size == '0) begin
			st = ST_ZERO;
		end else begin
			off = 64'(req.block_address) % 64'(CHUNK_ALIGN);
			lo = 64'(req.block_address) - off;
			len = ((64'(req.byte_size) + off + 64'(CHUNK_ALIGN - 1)) / 64'(CHUNK_ALIGN))
				* 64'(CHUNK_ALIGN);
			hi = lo + len;
			if (hi > ADDR_LIMIT) begin
				st = ST_RANGE;
			end else begin
				pos = 0;
				while (pos < ext_count && 64'(ext_base[pos]) < lo)
					pos++;
				has_pred = pos > 0;
				has_succ = pos < ext_count;
				pred_end = has_pred ? 64'(ext_base[pos-1]) + 64'(ext_len[pos-1]) : 64'd0;
				if (checks_on && ((has_succ && hi > 64'(ext_base[pos]))
						|| (has_pred && pred_end > lo))) begin
					st = ST_DOUBLE;
				end else begin
					join_pred = has_pred && pred_end == lo;
					join_succ = has_succ && hi == 64'(ext_base[pos]);
					if (join_pred && join_succ) begin
						// The new range bridges two extents; close the gap in the table.
						ext_len[pos-1] = LEN_W'(hi + 64'(ext_len[pos]) - 64'(ext_base[pos-1]));
						for (int i = pos; i < ext_count - 1; i++) begin
							ext_base[i] = ext_base[i+1];
							ext_len[i] = ext_len[i+1];
						end
						ext_count--;
					end else if (join_pred) begin
						ext_len[pos-1] = LEN_W'(hi - 64'(ext_base[pos-1]));
					end else if (join_succ) begin
						ext_len[pos] = LEN_W'(hi + 64'(ext_len[pos]) - lo);
						ext_base[pos] = lo[START_W-1:0];
					end else if (ext_count >= MAX_EXTENTS) begin
						st = ST_FULL;
					end else begin
						// Open a slot at the sorted position.
						for (int i = ext_count; i > pos; i--) begin
							ext_base[i] = ext_base[i-1];
							ext_len[i] = ext_len[i-1];
						end
						ext_base[pos] = lo[START_W-1:0];
						ext_len[pos] = len[LEN_W-1:0];
						ext_count++;
					end
					if (st == ST_FREED) begin
						free_sum = free_sum + len;
						if (free_sum > FREE_LIMIT)
							free_sum = FREE_LIMIT;
					end
				end
			end
		end
		res.status = st;
		res.free_total = free_sum[FREE_W-1:0];
		res.extent_count = COUNT_W'(ext_count);
		return res;
	endfunction

	function automatic void queue_free(logic [31:0] addr, logic [31:0] size);
		req_t req;
		req.block_address = addr;
		req.byte_size = size;
		pending_frees.push_back(req);
	endfunction

	// Free one region of the window as a shuffled run of equal blocks, so that the
	// pieces meet their neighbors from either side. Some blocks are given unaligned
	// and short, which widens back to the same block. Returns the number of items.
	function automatic int queue_region_batch();
		int r, blk_size, blk_count, j, tmp, o, trim;
		int order[$];
		logic [31:0] region_base, blk_addr;
		if (&region_used) begin
			window_base = $urandom & 32'hFFFF_E000;
			region_used = '0;
		end
		r = $urandom_range(31);
		if (region_used[r] && $urandom_range(99) < 85) begin
			while (region_used[r])
				r = (r + 1) % 32;
		end
		region_used[r] = 1'b1;
		region_base = window_base + 32'(r * 256);
		blk_size = 32 << $urandom_range(2);
		blk_count = 256 / blk_size;
		for (int k = 0; k < blk_count; k++)
			order.push_back(k);
		for (int k = blk_count - 1; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		foreach (order[k]) begin
			blk_addr = region_base + 32'(order[k] * blk_size);
			if ($urandom_range(2) == 0) begin
				o = $urandom_range(1, 7);
				trim = $urandom_range(7);
				queue_free(blk_addr + 32'(o), 32'(blk_size - o - trim));
			end else begin
				queue_free(blk_addr, 32'(blk_size));
			end
		end
		return blk_count;
	endfunction

	// Stray requests: zero sizes, fully random fields, the top of the address space, small random frees.
	function automatic void queue_noise_free();
		case ($urandom_range(3))
			0: queue_free($urandom, 32'd0);
			1: queue_free($urandom, $urandom);
			2: queue_free(32'hFFFF_FFFF - 32'($urandom_range(63)), 32'($urandom_range(1, 80)));
			default: queue_free($urandom, 32'($urandom_range(1, 64)));
		endcase
	endfunction

	function automatic void queue_random_frees(int target);
		int queued;
		queued = 0;
		while (queued < target) begin
			if ($urandom_range(99) < 85) begin
				queued += queue_region_batch();
			end else begin
				queue_noise_free();
				queued++;
			end
		end
	endfunction

	// Wait until every item has been sent and answered and the block is idle.
	task automatic wait_table_idle();
		do
			@(posedge clk);
		while (pending_frees.size() != 0 || start || busy || expected_free_reports.size() != 0);
	endtask

	task automatic set_overlap_checks(input bit enable);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= enable;
		@(posedge clk);
		cfg_we <= 1'b0;
		checks_on = enable;
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("Mismatch in %s: expected %0d, got %0d", field, want, got);
	endtask

	// Driver: predict each accepted item, then present the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy)
				expected_free_reports.push_back(coalesce_free(request));
			if (!start || !busy) begin
				if (pending_frees.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					request <= pending_frees.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each strobed result with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (expected_free_reports.size() == 0) begin
				report_mismatch("result with none pending, status", 64'd0, 64'(result.status));
			end else begin
				want = expected_free_reports.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(want.status), 64'(result.status));
				if (result.free_total !== want.free_total)
					report_mismatch("free_total", 64'(want.free_total), 64'(result.free_total));
				if (result.extent_count !== want.extent_count)
					report_mismatch("extent_count", 64'(want.extent_count),
						64'(result.extent_count));
			end
		end
	end

	// Stimulus sequence.
	initial begin
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		arst_n = 1'b0;
		window_base = $urandom & 32'hFFFF_E000;
		region_used = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_overlap_checks(1'b1);

		// Directed frees on an empty table with overlap checks on.
		queue_free(32'hFFFF_FFFF, 32'd0);
		queue_free(32'h0000_0000, 32'd0);
		queue_free(32'h0000_0100, 32'd8);
		queue_free(32'h0000_0108, 32'd8);
		queue_free(32'h0000_00F9, 32'd1);
		queue_free(32'h0000_0200, 32'd16);
		queue_free(32'h0000_0110, 32'h0000_00F0);
		queue_free(32'h0000_0104, 32'd4);
		queue_free(32'h0000_00F0, 32'd9);
		queue_free(32'hFFFF_FFF8, 32'd8);
		queue_free(32'hFFFF_FFFF, 32'd1);
		queue_free(32'hFFFF_FFF9, 32'hFFFF_FFFF);
		queue_free(32'h0000_0007, 32'hFFFF_FFFF);
		queue_free(32'h0000_0000, 32'hFFFF_FFF8);
		queue_free(32'h0000_0000, 32'h0000_00F8);
		queue_free(32'hFFFF_FFF0, 32'd8);
		queue_free(32'h0000_0210, 32'h0000_0010);
		queue_free(32'h0000_03FF, 32'd2);
		wait_table_idle();

		// Overlapping frees are inserted as their own extents when checks are off.
		set_overlap_checks(1'b0);
		queue_free(32'h0000_0104, 32'd4);
		queue_free(32'h0000_0400, 32'd8);
		queue_free(32'h0000_03F0, 32'd8);
		wait_table_idle();

		// Random region runs, first back to back, then with a mostly idle sender.
		set_overlap_checks(1'b1);
		queue_random_frees(250);
		wait_table_idle();
		sender_idle_pct = 78;
		queue_random_frees(200);
		wait_table_idle();

		set_overlap_checks(1'b0);
		sender_idle_pct = 6;
		queue_random_frees(120);
		wait_table_idle();

		// Fill the table with separated extents until it overflows, then close the gaps.
		set_overlap_checks(1'b1);
		sender_idle_pct = 30;
		window_base = $urandom & 32'hFFFF_F000;
		for (int k = 0; k < 70; k++)
			queue_free(window_base + 32'(16 * k), 32'd8);
		begin
			int gaps[$];
			int j, tmp;
			for (int k = 0; k < 69; k++)
				gaps.push_back(k);
			for (int k = 68; k > 0; k--) begin
				j = $urandom_range(k);
				tmp = gaps[k];
				gaps[k] = gaps[j];
				gaps[j] = tmp;
			end
			foreach (gaps[k])
				queue_free(window_base + 32'(16 * gaps[k] + 8), 32'd8);
		end
		wait_table_idle();

		sender_idle_pct = 0;
		window_base = $urandom & 32'hFFFF_E000;
		region_used = '0;
		queue_random_frees(60);
		wait_table_idle();

		// Whole address space freed twice with checks off drives the total to saturation.
		set_overlap_checks(1'b0);
		queue_free(32'h0000_0000, 32'hFFFF_FFFF);
		queue_free(32'h0000_0000, 32'hFFFF_FFFF);
		queue_free(32'h0000_0000, 32'd0);
		queue_free(32'h0000_0040, 32'd8);
		wait_table_idle();

		repeat (150) @(posedge clk);
		if (mismatch_count == 0 && expected_free_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
